// ===== hdl/isort_pkg.sv =====
`timescale 1ns / 1ps

package isort_pkg;

  localparam int DEPTH    = 64;
  localparam int KEY_BITS = 45;
  localparam int TAG_BITS = 16;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } rec_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== hdl/isort_ifs.sv =====
`timescale 1ns / 1ps

interface isort_in_if;
  logic                          valid;
  logic                          ready;
  logic [isort_pkg::KEY_BITS-1:0] sort_key;
  logic [isort_pkg::TAG_BITS-1:0] record_tag;
  logic                          set_end;

  modport source (output valid, output sort_key, output record_tag, output set_end,
                  input ready);
  modport sink (input valid, input sort_key, input record_tag, input set_end,
                output ready);
endinterface

interface isort_out_if;
  logic                          valid;
  logic                          ready;
  logic [isort_pkg::KEY_BITS-1:0] out_key;
  logic [isort_pkg::TAG_BITS-1:0] out_tag;
  logic                          out_final;
  logic                          overflow;

  modport source (output valid, output out_key, output out_tag, output out_final,
                  output overflow, input ready);
  modport sink (input valid, input out_key, input out_tag, input out_final,
                input overflow, output ready);
endinterface

// ===== hdl/isort_cell.sv =====
`timescale 1ns / 1ps

module isort_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  isort_pkg::cell_ctrl_t ctrl,
  input  isort_pkg::rec_t       new_rec,
  input  isort_pkg::rec_t       prev_rec,
  input  logic                  prev_valid,
  input  logic                  prev_gt,
  input  isort_pkg::rec_t       next_rec,
  input  logic                  next_valid,
  output isort_pkg::rec_t       rec,
  output logic                  valid,
  output logic                  gt
);
  import isort_pkg::*;

  logic take;

  // Strict compare keeps equal keys in arrival order.
  assign gt = valid && (rec.key > new_rec.key);

  // A cell moves up when it holds a greater key, or when it is the first free one.
  assign take = gt || (!valid && prev_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.insert && take) begin
      valid <= 1'b1;
    end else if (ctrl.shift) begin
      valid <= next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert && take) begin
      rec <= prev_gt ? prev_rec : new_rec;
    end else if (ctrl.shift) begin
      rec <= next_rec;
    end
  end

endmodule

// ===== hdl/insertion_sort_engine.sv =====
`timescale 1ns / 1ps

// Stable ascending sorter for records of a packed name key and a tag.
// Records enter on the rec channel. Each accepted record is placed by a
// chain of DEPTH cells that all compare against it at once, so records
// may arrive back to back, one per cycle, while a set is collected.
// The record with set_end high is inserted like the others, and then the
// chain drains in order on the res channel from the head cell, one result
// per cycle while res.ready is high, the first result in the cycle after
// that record is accepted. rec.ready stays low for the whole drain, and a
// stall on res.ready simply freezes the chain. out_final marks the last
// result of the set, and overflow on that result reports records dropped
// because the chain was full. A synchronous reset empties the chain and
// clears the drop flag.
module insertion_sort_engine (
  input logic     clk,
  input logic     rst,
  isort_in_if.sink   rec,
  isort_out_if.source res
);
  import isort_pkg::*;

  rec_t             new_rec;
  rec_t             cell_rec [DEPTH];
  logic [DEPTH-1:0] cell_valid;
  logic [DEPTH-1:0] cell_gt;
  cell_ctrl_t       ctrl;
  logic             draining;
  logic             dropped;
  logic             accept;
  logic             full;
  logic             last_out;

  assign new_rec.key = rec.sort_key;
  assign new_rec.tag = rec.record_tag;

  assign full     = cell_valid[DEPTH-1];
  assign rec.ready = !draining;
  assign accept   = rec.valid && !draining;
  assign last_out = !cell_valid[1];

  assign ctrl.insert = accept && !full;
  assign ctrl.shift  = draining && res.ready;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      rec_t prev_rec;
      logic prev_valid;
      logic prev_gt;
      rec_t next_rec;
      logic next_valid;

      if (i == 0) begin : g_head
        assign prev_rec   = new_rec;
        assign prev_valid = 1'b1;
        assign prev_gt    = 1'b0;
      end else begin : g_body
        assign prev_rec   = cell_rec[i-1];
        assign prev_valid = cell_valid[i-1];
        assign prev_gt    = cell_gt[i-1];
      end

      if (i == DEPTH-1) begin : g_tail
        assign next_rec   = new_rec;
        assign next_valid = 1'b0;
      end else begin : g_mid
        assign next_rec   = cell_rec[i+1];
        assign next_valid = cell_valid[i+1];
      end

      isort_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .new_rec    (new_rec),
        .prev_rec   (prev_rec),
        .prev_valid (prev_valid),
        .prev_gt    (prev_gt),
        .next_rec   (next_rec),
        .next_valid (next_valid),
        .rec        (cell_rec[i]),
        .valid      (cell_valid[i]),
        .gt         (cell_gt[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      dropped  <= 1'b0;
    end else begin
      if (accept && full) begin
        dropped <= 1'b1;
      end
      if (accept && rec.set_end) begin
        draining <= 1'b1;
      end else if (ctrl.shift && last_out) begin
        draining <= 1'b0;
        dropped  <= 1'b0;
      end
    end
  end

  assign res.valid     = draining;
  assign res.out_key   = cell_rec[0].key;
  assign res.out_tag   = cell_rec[0].tag;
  assign res.out_final = last_out;
  assign res.overflow  = last_out && dropped;

endmodule
